@@ rtl/odc_pkg.sv @@
// ============================================================================
// Octave and DAC word calculator - shared package
// Field widths, octave thresholds, divider sizing and the request entry that
// travels from the front end, through the queue, to the divider back end.
// ============================================================================
package odc_pkg;

    localparam int FREQ_W     = 27;
    localparam int OCT_W      = 4;
    localparam int DAC_W      = 10;
    localparam int WORD_W     = 16;
    localparam int QUOT_W     = 12;
    localparam int DIVIDEND_W = 38;
    localparam int REM_CMP_W  = 40;
    localparam int NUM_THRESH = 15;

    // Strictly-greater thresholds; the octave is the number of them exceeded.
    localparam logic [FREQ_W-1:0] OCT_THRESH [NUM_THRESH] = '{
        27'd2076,    27'd4152,    27'd8304,    27'd16610,   27'd33220,
        27'd66430,   27'd132900,  27'd265700,  27'd531400,  27'd1063000,
        27'd2126000, 27'd4252000, 27'd8503000, 27'd17010000, 27'd34010000
    };

    // Twice 2078 * 2^10; shifted left by the octave it gives the numerator.
    localparam logic [DIVIDEND_W-1:0] NUM_BASE = 38'd4255744;

    // The code is 2048 minus the quotient; quotients outside 1025..2048 clamp.
    localparam logic [QUOT_W-1:0] Q_CODE_ZERO = 12'd2048;
    localparam logic [QUOT_W-1:0] Q_CODE_TOP  = 12'd1025;
    localparam logic [DAC_W-1:0]  DAC_MAX     = 10'd1023;

    typedef struct packed {
        logic [OCT_W-1:0]      oct;
        logic                  zero;
        logic [FREQ_W-1:0]     freq;
        logic [DIVIDEND_W-1:0] dividend;
    } entry_t;

endpackage

@@ rtl/oscillator_octave_dac_calculator_core.sv @@
// ============================================================================
// Octave and DAC word calculator - top level
// Turns a requested frequency into an octave, a ten-bit DAC code and the
// packed sixteen-bit control word of a programmable oscillator.
// ============================================================================
// Usage. Both sides look like a queue. A frequency request is written with
// push while full is low; a result is read from the output ports while empty
// is low and is removed with pop. Each request gives exactly one result, in
// request order.
// The front end classifies a request in the cycle it is written and places
// it in a short request queue. The back end is a restoring divider with one
// quotient bit per stage; a request passes from the queue through the
// divider stage registers to the result register. One request can be
// written and one result read in every cycle; the rate is set by the
// divider pipeline, which takes a new request each cycle it advances.
// If the reader stalls, the result register holds its value, the divider
// pipeline freezes and the request queue fills; full rises once its
// QUEUE_DEPTH entries are taken. Reset empties the queue and clears every
// valid flag, so empty is high and full is low after reset. No state links
// one request with the next.
// ============================================================================
module oscillator_octave_dac_calculator_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [odc_pkg::FREQ_W-1:0]  frequency_hz,
    output logic                        empty,
    input  logic                        pop,
    output logic [odc_pkg::OCT_W-1:0]   octave,
    output logic [odc_pkg::DAC_W-1:0]   dac_code,
    output logic [odc_pkg::WORD_W-1:0]  control_word,
    output logic                        range_error
);

    odc_pkg::entry_t front_entry;
    odc_pkg::entry_t head_entry;
    logic            queue_empty;
    logic            back_take;
    logic            back_valid;

    // Front end: octave choice, zero detection and dividend.
    odc_front u_front
    (
        .freq  (frequency_hz),
        .entry (front_entry)
    );

    // Request queue between the front end and the divider.
    odc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (front_entry),
        .full     (full),
        .pop      (back_take),
        .empty    (queue_empty),
        .rd_entry (head_entry)
    );

    // Back end: divider pipeline, clamp and result register.
    odc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!queue_empty),
        .in_entry  (head_entry),
        .in_take   (back_take),
        .out_valid (back_valid),
        .out_pop   (pop),
        .out_oct   (octave),
        .out_dac   (dac_code),
        .out_err   (range_error)
    );

    assign empty        = !back_valid;
    // The two low configuration bits of the word are always zero.
    assign control_word = {octave, dac_code, 2'b00};

endmodule

@@ rtl/odc_front.sv @@
// ============================================================================
// Octave and DAC word calculator - front end
// Classifies a request: picks the octave, flags a zero frequency and forms
// the dividend of the rounded division for the back end.
// ============================================================================
module odc_front
(
    input  logic [odc_pkg::FREQ_W-1:0] freq,
    output odc_pkg::entry_t            entry
);

    logic [odc_pkg::OCT_W-1:0] oct;

    // Thresholds rise monotonically, so the last one exceeded sets the octave.
    always_comb
    begin
        oct = '0;
        for (int i = 0; i < odc_pkg::NUM_THRESH; i++)
        begin
            if (freq > odc_pkg::OCT_THRESH[i])
            begin
                oct = odc_pkg::OCT_W'(i + 1);
            end
        end
    end

    // The dividend is N + f - 1 with N = 4156 * 2^(10+octave), which turns
    // the ceiling needed for the rounding into a plain floor division by 2f.
    always_comb
    begin
        entry.oct      = oct;
        entry.zero     = (freq == '0);
        entry.freq     = freq;
        entry.dividend = (odc_pkg::NUM_BASE << oct)
                       + odc_pkg::DIVIDEND_W'(freq)
                       - odc_pkg::DIVIDEND_W'(1);
    end

endmodule

@@ rtl/odc_queue.sv @@
// ============================================================================
// Octave and DAC word calculator - request queue
// A short first-in first-out queue of classified requests that decouples the
// front end from the divider back end.
// ============================================================================
module odc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  odc_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output odc_pkg::entry_t rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    odc_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ rtl/odc_back.sv @@
// ============================================================================
// Octave and DAC word calculator - divider back end
// A pipelined restoring divider, one quotient bit per stage, followed by the
// clamp to the ten-bit code and the result register.
// ============================================================================
module odc_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  odc_pkg::entry_t            in_entry,
    output logic                       in_take,
    output logic                       out_valid,
    input  logic                       out_pop,
    output logic [odc_pkg::OCT_W-1:0]  out_oct,
    output logic [odc_pkg::DAC_W-1:0]  out_dac,
    output logic                       out_err
);

    localparam int QW = odc_pkg::QUOT_W;
    localparam int CW = odc_pkg::REM_CMP_W;

    typedef struct packed {
        logic [odc_pkg::OCT_W-1:0]      oct;
        logic                           zero;
        logic                           ovf;
        logic [odc_pkg::FREQ_W-1:0]     freq;
        logic [odc_pkg::DIVIDEND_W-1:0] rem;
        logic [QW-1:0]                  quot;
    } stage_t;

    stage_t                    stage_reg [QW+1];
    stage_t                    stage0_next;
    logic [QW:0]               valid_reg;
    logic                      adv;
    logic                      out_valid_reg;
    logic [odc_pkg::OCT_W-1:0] oct_reg;
    logic [odc_pkg::DAC_W-1:0] dac_reg;
    logic [odc_pkg::DAC_W-1:0] dac_next;
    logic                      err_reg;
    logic                      err_next;

    // The whole pipeline moves together whenever the result register is free.
    assign adv       = !out_valid_reg || out_pop;
    assign in_take   = adv && in_valid;
    assign out_valid = out_valid_reg;
    assign out_oct   = oct_reg;
    assign out_dac   = dac_reg;
    assign out_err   = err_reg;

    // A quotient of 4096 or more only ever clamps, so it is flagged up front.
    always_comb
    begin
        stage0_next.oct  = in_entry.oct;
        stage0_next.zero = in_entry.zero;
        stage0_next.freq = in_entry.freq;
        stage0_next.rem  = in_entry.dividend;
        stage0_next.quot = '0;
        stage0_next.ovf  = CW'(in_entry.dividend) >= (CW'({in_entry.freq, 1'b0}) << QW);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg[0] <= stage0_next;
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_step
        logic [CW-1:0] div_shift;
        logic          take_bit;
        stage_t        stage_next;

        assign div_shift = CW'({stage_reg[s-1].freq, 1'b0}) << (QW - s);
        assign take_bit  = CW'(stage_reg[s-1].rem) >= div_shift;

        always_comb
        begin
            stage_next      = stage_reg[s-1];
            stage_next.quot = {stage_reg[s-1].quot[QW-2:0], take_bit};
            if (take_bit)
            begin
                stage_next.rem = odc_pkg::DIVIDEND_W'(CW'(stage_reg[s-1].rem) - div_shift);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[s] <= stage_next;
            end
        end
    end

    // The code is 2048 minus the quotient, saturated to the ten-bit range.
    always_comb
    begin
        dac_next = '0;
        err_next = 1'b0;
        if (stage_reg[QW].zero || stage_reg[QW].ovf
            || (stage_reg[QW].quot > odc_pkg::Q_CODE_ZERO))
        begin
            err_next = 1'b1;
        end
        else if (stage_reg[QW].quot < odc_pkg::Q_CODE_TOP)
        begin
            dac_next = odc_pkg::DAC_MAX;
            err_next = 1'b1;
        end
        else
        begin
            dac_next = odc_pkg::DAC_W'(odc_pkg::Q_CODE_ZERO - stage_reg[QW].quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[QW-1:0], in_valid};
            out_valid_reg <= valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_reg[QW])
        begin
            oct_reg <= stage_reg[QW].oct;
            dac_reg <= dac_next;
            err_reg <= err_next;
        end
    end

endmodule
